/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent while out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/mmbd_pkg.sv */
// Shared constants and types of the min/max bucket decimator.
`default_nettype none

package mmbd_pkg;

  localparam int SAMPLE_BITS_DEF       = 16;
  localparam int MAX_BUCKET_LOG2_DEF   = 20;
  localparam int BUCKET_INDEX_BITS_DEF = 32;

  localparam int              CFG_BITS          = 5;
  localparam logic [CFG_BITS-1:0] BUCKET_LOG2_RESET = CFG_BITS'(1);

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_GAP   = 1'b1;

  typedef struct packed {
    logic push0;
    logic push1;
  } emit_t;

endpackage

`default_nettype wire

/* rtl/mmbd_tracker.sv */
// Running min/max tracker of one bucket and the result items of a closing bucket.
`default_nettype none

module mmbd_tracker
  import mmbd_pkg::*;
#(
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int MAX_BUCKET_LOG2   = MAX_BUCKET_LOG2_DEF,
  parameter int BUCKET_INDEX_BITS = BUCKET_INDEX_BITS_DEF,
  parameter int LG_W              = $clog2(MAX_BUCKET_LOG2 + 1),
  parameter int RES_W             = SAMPLE_BITS + BUCKET_INDEX_BITS + 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_fire,
  input  wire logic [SAMPLE_BITS-1:0]  in_sample,
  input  wire logic                    in_draw,
  input  wire logic                    in_last,
  input  wire logic [LG_W-1:0]         lg,
  output emit_t                        emit,
  output logic      [RES_W-1:0]        res0,
  output logic      [RES_W-1:0]        res1
);

  localparam int POS_W = MAX_BUCKET_LOG2;

  logic        [POS_W-1:0]             pos_r;
  logic        [BUCKET_INDEX_BITS-1:0] cnt_r;
  logic signed [SAMPLE_BITS-1:0]       lo_r, hi_r;
  logic        [POS_W-1:0]             lo_pos_r, hi_pos_r;
  logic                                any_r;

  logic signed [SAMPLE_BITS-1:0]       smp;
  logic signed [SAMPLE_BITS-1:0]       lo_nxt, hi_nxt;
  logic        [POS_W-1:0]             lo_pos_nxt, hi_pos_nxt;
  logic                                any_nxt;
  logic                                first, lo_upd, hi_upd, close_b, two;
  logic        [POS_W-1:0]             end_mask;
  logic signed [SAMPLE_BITS-1:0]       most_pos, most_neg;

  assign most_pos = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  assign most_neg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  assign smp      = in_sample;
  assign end_mask = ~({POS_W{1'b1}} << lg);

  always_comb begin
    first      = in_draw && !any_r;
    lo_upd     = in_draw && (first || (smp < lo_r));
    hi_upd     = in_draw && (first || (smp > hi_r));
    lo_nxt     = lo_upd ? smp : lo_r;
    hi_nxt     = hi_upd ? smp : hi_r;
    lo_pos_nxt = lo_upd ? pos_r : lo_pos_r;
    hi_pos_nxt = hi_upd ? pos_r : hi_pos_r;
    any_nxt    = any_r || in_draw;
    close_b    = (pos_r >= end_mask) || in_last;
    two        = any_nxt && (lo_pos_nxt != hi_pos_nxt);

    // Result layout from the lowest bit: kind, value, at_middle, bucket number, last.
    res1 = {1'b1, cnt_r, 1'b1, (lo_pos_nxt < hi_pos_nxt) ? hi_nxt : lo_nxt, KIND_POINT};
    if (!any_nxt) begin
      res0 = {1'b1, cnt_r, 1'b0, {SAMPLE_BITS{1'b0}}, KIND_GAP};
    end else if (!two) begin
      res0 = {1'b1, cnt_r, 1'b0, lo_nxt, KIND_POINT};
    end else if (lo_pos_nxt < hi_pos_nxt) begin
      res0 = {1'b0, cnt_r, 1'b0, lo_nxt, KIND_POINT};
    end else begin
      res0 = {1'b0, cnt_r, 1'b0, hi_nxt, KIND_POINT};
    end

    emit.push0 = in_fire && close_b;
    emit.push1 = in_fire && close_b && two;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      cnt_r    <= '0;
      lo_r     <= most_pos;
      hi_r     <= most_neg;
      lo_pos_r <= '0;
      hi_pos_r <= '0;
      any_r    <= 1'b0;
    end else if (in_fire) begin
      if (close_b) begin
        pos_r    <= '0;
        cnt_r    <= in_last ? '0 : cnt_r + BUCKET_INDEX_BITS'(1);
        lo_r     <= most_pos;
        hi_r     <= most_neg;
        lo_pos_r <= '0;
        hi_pos_r <= '0;
        any_r    <= 1'b0;
      end else begin
        pos_r    <= pos_r + POS_W'(1);
        lo_r     <= lo_nxt;
        hi_r     <= hi_nxt;
        lo_pos_r <= lo_pos_nxt;
        hi_pos_r <= hi_pos_nxt;
        any_r    <= any_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/mmbd_fifo.sv */
// Four-entry result queue that takes up to two result items per cycle.
`default_nettype none

module mmbd_fifo
  import mmbd_pkg::*;
#(
  parameter int RES_W = SAMPLE_BITS_DEF + BUCKET_INDEX_BITS_DEF + 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire emit_t            emit,
  input  wire logic [RES_W-1:0] res0,
  input  wire logic [RES_W-1:0] res1,
  output logic                  room_two,
  output logic                  rd_valid,
  input  wire logic             rd_pop,
  output logic      [RES_W-1:0] rd_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  logic [RES_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W:0]   count_nxt;
  logic             pop;

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign pop      = rd_valid && rd_pop;
  assign room_two = (count_r <= (PTR_W+1)'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(emit.push0) + PTR_W'(emit.push1);
    count_nxt  = count_r + (PTR_W+1)'(emit.push0) + (PTR_W+1)'(emit.push1)
                 - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (emit.push0) begin
      mem_r[wr_ptr_r] <= res0;
    end
    if (emit.push1) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/minmax_bucket_decimator.sv */
// Top level of the min/max bucket decimator.
// The block takes one sample beat per cycle while in_tready is high and updates the
// running extremes of the current bucket in that same cycle; a closing bucket writes one
// or two result items into a four-entry queue that feeds the output, one result beat per
// cycle while out_tready is high. Input is taken while the queue holds at most two
// results, so with the output always ready the block sustains one sample per cycle for
// every bucket size, buckets of two samples that yield two results each included.
// Results are registered in the queue. Write cfg_wr_data only while the block is idle.
`default_nettype none

module minmax_bucket_decimator
  import mmbd_pkg::*;
#(
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int MAX_BUCKET_LOG2   = MAX_BUCKET_LOG2_DEF,
  parameter int BUCKET_INDEX_BITS = BUCKET_INDEX_BITS_DEF,
  parameter int IN_DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_DATA_W        = ((SAMPLE_BITS + BUCKET_INDEX_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_BITS-1:0]   cfg_wr_data,   // bucket_log2
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,      // sample
  input  wire logic                  in_tuser,      // drawable
  input  wire logic                  in_tlast,      // last_sample
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,     // value, at_middle, bucket_number
  output logic                       out_tuser,     // kind
  output logic                       out_tlast      // last_of_run
);

  localparam int LG_W  = $clog2(MAX_BUCKET_LOG2 + 1);
  localparam int RES_W = SAMPLE_BITS + BUCKET_INDEX_BITS + 3;
  localparam int PAY_W = SAMPLE_BITS + BUCKET_INDEX_BITS + 1;

  logic [CFG_BITS-1:0] bucket_log2_r;
  logic [LG_W-1:0]     lg;
  logic                in_fire;
  logic                room_two;
  emit_t               emit;
  logic [RES_W-1:0]    res0, res1, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_log2_r <= BUCKET_LOG2_RESET;
    end else if (cfg_wr_en) begin
      bucket_log2_r <= cfg_wr_data;
    end
  end

  assign lg = (32'(bucket_log2_r) > 32'(MAX_BUCKET_LOG2)) ? LG_W'(MAX_BUCKET_LOG2)
                                                          : LG_W'(bucket_log2_r);

  assign in_tready = room_two;
  assign in_fire   = in_tvalid && in_tready;

  mmbd_tracker #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .MAX_BUCKET_LOG2  (MAX_BUCKET_LOG2),
    .BUCKET_INDEX_BITS(BUCKET_INDEX_BITS),
    .LG_W             (LG_W),
    .RES_W            (RES_W)
  ) u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_sample(in_tdata[SAMPLE_BITS-1:0]),
    .in_draw  (in_tuser),
    .in_last  (in_tlast),
    .lg       (lg),
    .emit     (emit),
    .res0     (res0),
    .res1     (res1)
  );

  mmbd_fifo #(
    .RES_W(RES_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .emit    (emit),
    .res0    (res0),
    .res1    (res1),
    .room_two(room_two),
    .rd_valid(out_tvalid),
    .rd_pop  (out_tready),
    .rd_data (rd_data)
  );

  assign out_tuser = rd_data[0];
  assign out_tlast = rd_data[RES_W-1];
  assign out_tdata = OUT_DATA_W'(rd_data[PAY_W:1]);

endmodule

`default_nettype wire

/* rtl/mmbd_checker.sv */
// Port-level checker of the min/max bucket decimator and its bind.
`default_nettype none
`include "assert_macros.svh"

module mmbd_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int OUT_DATA_W  = 56
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  out_tlast
);

  `ASSERT_NEXT_ALWAYS(a_idle_after_reset, clk, !rst_n, !out_tvalid)
  `ASSERT_IMPLIES(a_gap_is_alone, clk, rst_n, out_tvalid && out_tuser,
                  out_tlast && (out_tdata[SAMPLE_BITS-1:0] == '0) && !out_tdata[SAMPLE_BITS])
  `ASSERT_IMPLIES(a_middle_ends_run, clk, rst_n, out_tvalid && out_tdata[SAMPLE_BITS],
                  out_tlast)
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind minmax_bucket_decimator mmbd_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .OUT_DATA_W (OUT_DATA_W)
) u_mmbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

`default_nettype wire
